// ----- sv/cc20_pkg.sv -----
// Shared types, constants and round functions for the ChaCha20 byte cipher.
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

  localparam int NUM_KEY_WORDS = 8;
  localparam int CFG_INDEX_W   = 3;
  localparam int ROUNDS        = 20;

  typedef logic [15:0][31:0] block_t;
  typedef logic [NUM_KEY_WORDS-1:0][31:0] key_t;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // Built-in key, word 0 in the lowest slot.
  localparam key_t KEY_RESET = {
    32'd2227873595, 32'd1779033703, 32'd3144134277, 32'd1701995116,
    32'd1623235827, 32'd360467071,  32'd3111729054, 32'd1397769043
  };

  // One queued byte together with everything needed to build its block.
  typedef struct packed {
    logic [7:0]  data;
    logic [5:0]  offset;
    logic        new_block;
    logic [63:0] counter;
    logic [63:0] nonce;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } core_state_t;

  function automatic logic [127:0] quarter(input logic [31:0] a_in, input logic [31:0] b_in,
                                           input logic [31:0] c_in, input logic [31:0] d_in);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = a_in;
    b = b_in;
    c = c_in;
    d = d_in;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    return {a, b, c, d};
  endfunction

  // A column round when diag is low, a diagonal round when it is high.
  function automatic block_t chacha_round(input block_t w, input logic diag);
    block_t       r;
    logic [3:0]   ia;
    logic [3:0]   ib;
    logic [3:0]   ic;
    logic [3:0]   id;
    logic [127:0] q;
    r = w;
    for (int i = 0; i < 4; i++) begin
      ia = 4'(i);
      ib = diag ? 4'(4 + ((i + 1) & 3))  : 4'(4 + i);
      ic = diag ? 4'(8 + ((i + 2) & 3))  : 4'(8 + i);
      id = diag ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
      q = quarter(w[ia], w[ib], w[ic], w[id]);
      r[ia] = q[127:96];
      r[ib] = q[95:64];
      r[ic] = q[63:32];
      r[id] = q[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cc20_front.sv -----
// Front end: accepts bytes, tracks offset, counter and nonce, tags block starts.
`timescale 1ns / 1ps
`default_nettype none

module cc20_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            data_valid,
  output logic                 data_stall,
  input  wire logic [7:0]      data_byte,
  input  wire logic            start_of_message,
  input  wire logic [63:0]     message_nonce,
  input  wire logic            queue_full,
  output logic                 push,
  output cc20_pkg::item_t      item
);

  logic [5:0]  offset;
  logic [63:0] counter;
  logic [63:0] nonce;

  logic [5:0]  eff_offset;
  logic [63:0] eff_counter;
  logic [63:0] eff_nonce;
  logic        new_block;

  assign data_stall = queue_full;
  assign push       = data_valid && !queue_full;

  always_comb begin
    eff_offset  = start_of_message ? 6'd0 : offset;
    eff_counter = start_of_message ? 64'd0 : counter;
    eff_nonce   = start_of_message ? message_nonce : nonce;
    new_block   = (eff_offset == 6'd0);
    item.data      = data_byte;
    item.offset    = eff_offset;
    item.new_block = new_block;
    item.counter   = eff_counter;
    item.nonce     = eff_nonce;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset  <= 6'd0;
      counter <= 64'd0;
      nonce   <= 64'd0;
    end else if (push) begin
      offset  <= eff_offset + 6'd1;
      counter <= new_block ? eff_counter + 64'd1 : eff_counter;
      nonce   <= eff_nonce;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cc20_fifo.sv -----
// Short queue of tagged bytes between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module cc20_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cc20_pkg::item_t  push_item,
  input  wire logic             pop,
  output cc20_pkg::item_t       head,
  output logic                  head_valid,
  output logic                  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cc20_pkg::item_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cc20_core.sv -----
// Block function: one round per cycle over a shared round unit, then feed-forward.
`timescale 1ns / 1ps
`default_nettype none

module cc20_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [63:0]     counter,
  input  wire logic [63:0]     nonce,
  input  wire cc20_pkg::key_t  key,
  output cc20_pkg::core_stat_t stat,
  output cc20_pkg::block_t     block
);

  cc20_pkg::core_state_t state;
  cc20_pkg::core_state_t state_next;
  logic [4:0]            rnd;
  cc20_pkg::block_t      init;
  cc20_pkg::block_t      work;
  cc20_pkg::block_t      load;
  cc20_pkg::block_t      ff_sum;

  always_comb begin
    load = {nonce[63:32], nonce[31:0], counter[63:32], counter[31:0], key,
            cc20_pkg::SIGMA3, cc20_pkg::SIGMA2, cc20_pkg::SIGMA1, cc20_pkg::SIGMA0};
    for (int i = 0; i < 16; i++) begin
      ff_sum[i] = work[i] + init[i];
    end
  end

  always_comb begin
    state_next = state;
    stat.busy  = (state != cc20_pkg::CORE_IDLE);
    stat.done  = 1'b0;
    case (state)
      cc20_pkg::CORE_IDLE: begin
        if (start) begin
          state_next = cc20_pkg::CORE_ROUND;
        end
      end
      cc20_pkg::CORE_ROUND: begin
        if (rnd == 5'(cc20_pkg::ROUNDS - 1)) begin
          state_next = cc20_pkg::CORE_ADD;
        end
      end
      cc20_pkg::CORE_ADD: begin
        stat.done  = 1'b1;
        state_next = cc20_pkg::CORE_IDLE;
      end
      default: begin
        state_next = cc20_pkg::CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cc20_pkg::CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working words double as the finished keystream block once the add is done.
  always_ff @(posedge clk) begin
    case (state)
      cc20_pkg::CORE_IDLE: begin
        if (start) begin
          init <= load;
          work <= load;
          rnd  <= 5'd0;
        end
      end
      cc20_pkg::CORE_ROUND: begin
        work <= cc20_pkg::chacha_round(work, rnd[0]);
        rnd  <= rnd + 5'd1;
      end
      cc20_pkg::CORE_ADD: begin
        work <= ff_sum;
      end
      default: begin
      end
    endcase
  end

  assign block = work;

endmodule

`default_nettype wire

// ----- sv/cc20_back.sv -----
// Back end: launches block computations, XORs keystream bytes, holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module cc20_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cc20_pkg::item_t  head,
  input  wire logic             head_valid,
  output logic                  pop,
  input  wire cc20_pkg::key_t   key,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [7:0]            result_byte
);

  cc20_pkg::core_stat_t stat;
  cc20_pkg::block_t     block;
  logic                 fresh;
  logic                 start;
  logic                 out_free;
  logic [31:0]          ks_word;
  logic [7:0]           ks_byte;

  // A byte that opens a block waits until that block has been computed for it.
  assign start    = head_valid && head.new_block && !fresh && !stat.busy;
  assign out_free = !result_valid || !result_stall;
  assign pop      = head_valid && (!head.new_block || fresh) && out_free;

  assign ks_word = block[head.offset[5:2]];
  assign ks_byte = 8'(ks_word >> {head.offset[1:0], 3'b000});

  cc20_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .counter (head.counter),
    .nonce   (head.nonce),
    .key     (key),
    .stat    (stat),
    .block   (block)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        fresh <= 1'b0;
      end else if (stat.done) begin
        fresh <= 1'b1;
      end
      if (pop) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_byte <= head.data ^ ks_byte;
    end
  end

endmodule

`default_nettype wire

// ----- sv/chacha20_stream_xor_top.sv -----
// Top level of the ChaCha20 byte stream cipher: key registers, front end, queue, back end.
// A byte inside a block passes through a queue entry and then the result register.
// A byte that opens a block also waits for the block function on the shared round
// unit (load, 20 rounds, feed-forward add) before it is taken from the queue.
// Sustained rate: one byte per cycle within a block while result_stall stays low.
// Synchronous reset loads the built-in key, clears offset, counter, nonce and the queue.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_xor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             data_valid,
  output logic                                  data_stall,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             start_of_message,
  input  wire logic [63:0]                      message_nonce,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [7:0]                            result_byte,
  input  wire logic                             cfg_write_en,
  input  wire logic [cc20_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  cc20_pkg::key_t  key;
  cc20_pkg::item_t push_item;
  cc20_pkg::item_t head;
  logic            push;
  logic            pop;
  logic            head_valid;
  logic            queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= cc20_pkg::KEY_RESET;
    end else if (cfg_write_en) begin
      key[cfg_index] <= cfg_data;
    end
  end

  cc20_front u_front (
    .clk              (clk),
    .rst              (rst),
    .data_valid       (data_valid),
    .data_stall       (data_stall),
    .data_byte        (data_byte),
    .start_of_message (start_of_message),
    .message_nonce    (message_nonce),
    .queue_full       (queue_full),
    .push             (push),
    .item             (push_item)
  );

  cc20_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  cc20_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .key          (key),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_byte  (result_byte)
  );

endmodule

`default_nettype wire

// ----- sv/cc20_checker.sv -----
// Port-level checker for the cipher top level, attached by bind.
`timescale 1ns / 1ps
`default_nettype none

module cc20_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       data_valid,
  input wire logic       data_stall,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [7:0] result_byte
);

  logic [15:0] pending;
  logic        in_beat;
  logic        out_beat;

  assign in_beat  = data_valid && !data_stall;
  assign out_beat = result_valid && !result_stall;

  // Bytes accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 16'd0;
    end else if (in_beat && !out_beat) begin
      pending <= pending + 16'd1;
    end else if (out_beat && !in_beat) begin
      pending <= pending - 16'd1;
    end
  end

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_no_result_without_input: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pending != 16'd0))
    else $error("result shown with no byte outstanding");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_byte))
    else $error("stalled result changed");

endmodule

bind chacha20_stream_xor_top cc20_checker u_cc20_checker (
  .clk          (clk),
  .rst          (rst),
  .data_valid   (data_valid),
  .data_stall   (data_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_byte  (result_byte)
);

`default_nettype wire

// ----- tb/sv/chacha20_stream_xor_top_tb.sv -----
// Self-checking testbench for the ChaCha20 byte stream cipher with a keystream scoreboard.
`timescale 1ns / 1ps

module chacha20_stream_xor_top_tb;

  typedef enum logic [cc20_pkg::CFG_INDEX_W-1:0] {
    KEY_WORD_0, KEY_WORD_1, KEY_WORD_2, KEY_WORD_3,
    KEY_WORD_4, KEY_WORD_5, KEY_WORD_6, KEY_WORD_7
  } key_reg_e;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  bit                   clk;
  logic                 rst = 1'b1;
  logic                 data_valid = 1'b0;
  logic                 data_stall;
  logic [7:0]           data_byte = '0;
  logic                 start_of_message = 1'b0;
  logic [63:0]          message_nonce = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [7:0]           result_byte;
  logic                 cfg_write_en = 1'b0;
  logic [cc20_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  chacha20_stream_xor_top dut (
    .clk              (clk),
    .rst              (rst),
    .data_valid       (data_valid),
    .data_stall       (data_stall),
    .data_byte        (data_byte),
    .start_of_message (start_of_message),
    .message_nonce    (message_nonce),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result_byte      (result_byte),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Tracks the cipher state and the expected result bytes still owed by the design.
  class KeystreamScoreboard;
    bit [31:0] key_words [cc20_pkg::NUM_KEY_WORDS];
    bit [31:0] block_words [16];
    bit [31:0] work [16];
    bit [5:0]  offset;
    bit [63:0] counter;
    bit [63:0] nonce;
    bit [7:0]  expected_bytes [$];
    int        errors = 0;

    function void clear();
      for (int i = 0; i < cc20_pkg::NUM_KEY_WORDS; i++) key_words[i] = cc20_pkg::KEY_RESET[i];
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      offset  = '0;
      counter = '0;
      nonce   = '0;
      expected_bytes.delete();
    endfunction

    function void set_key(key_reg_e idx, bit [31:0] value);
      key_words[idx] = value;
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int unsigned s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void mix(int a, int b, int c, int d);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
    endfunction

    function void next_block();
      bit [31:0] init [16];
      init[0] = cc20_pkg::SIGMA0;
      init[1] = cc20_pkg::SIGMA1;
      init[2] = cc20_pkg::SIGMA2;
      init[3] = cc20_pkg::SIGMA3;
      for (int i = 0; i < cc20_pkg::NUM_KEY_WORDS; i++) init[4 + i] = key_words[i];
      init[12] = counter[31:0];
      init[13] = counter[63:32];
      init[14] = nonce[31:0];
      init[15] = nonce[63:32];
      work = init;
      for (int r = 0; r < cc20_pkg::ROUNDS / 2; r++) begin
        mix(0, 4, 8, 12);
        mix(1, 5, 9, 13);
        mix(2, 6, 10, 14);
        mix(3, 7, 11, 15);
        mix(0, 5, 10, 15);
        mix(1, 6, 11, 12);
        mix(2, 7, 8, 13);
        mix(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) block_words[i] = work[i] + init[i];
      counter++;
    endfunction

    function void note_beat(bit [7:0] data, bit start, bit [63:0] nonce_in);
      bit [31:0] word;
      if (start) begin
        nonce   = nonce_in;
        counter = '0;
        offset  = '0;
      end
      if (offset == 0) next_block();
      word = block_words[offset[5:2]] >> (8 * offset[1:0]);
      expected_bytes.push_back(data ^ word[7:0]);
      offset++;
    endfunction

    function void check_result(bit [7:0] actual);
      bit [7:0] want;
      if (expected_bytes.size() == 0) begin
        $error("result_byte: expected nothing, actual %02h", actual);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (actual !== want) begin
        $error("result_byte: expected %02h, actual %02h", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  KeystreamScoreboard sb;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       sender_steady = 1'b0;
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_mode_left = 0;

  // The receiver switches between stall patterns of random length.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN:     result_stall <= 1'b0;
      RX_RANDOM:   result_stall <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: result_stall <= ((cycle_count % 5) < 2);
      default:     result_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst && result_valid && !result_stall) begin
      sb.check_result(result_byte);
    end
  end

  task automatic write_key(key_reg_e idx, bit [31:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    sb.set_key(idx, value);
    @(negedge clk);
  endtask

  task automatic load_keys(bit [255:0] value);
    for (int i = 0; i < cc20_pkg::NUM_KEY_WORDS; i++) begin
      write_key(key_reg_e'(i), value[32*i +: 32]);
    end
    cfg_write_en <= 1'b0;
  endtask

  // Entered and left at a falling edge; valid stays high across a burst.
  task automatic send_beat(bit [7:0] d, bit s, bit [63:0] n);
    int gap;
    if (burst_left == 0) begin
      if (!sender_steady) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        data_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    data_valid       <= 1'b1;
    data_byte        <= d;
    start_of_message <= s;
    message_nonce    <= n;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    sb.note_beat(d, s, n);
    @(negedge clk);
  endtask

  // A stray start flag inside a message restarts the stream mid-block.
  task automatic send_message(int len, bit lead_start);
    bit        s;
    bit [63:0] n;
    for (int k = 0; k < len; k++) begin
      s = (k == 0) ? lead_start : ($urandom_range(0, 49) == 0);
      case ($urandom_range(0, 19))
        0:       n = '0;
        1:       n = '1;
        default: n = {$urandom, $urandom};
      endcase
      send_beat(8'($urandom_range(0, 255)), s, n);
    end
  endtask

  task automatic run_traffic(int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 19))
        0:          len = $urandom_range(150, 260);
        1, 2, 3, 4: len = $urandom_range(65, 140);
        default:    len = $urandom_range(1, 64);
      endcase
      if (len > items - sent) len = items - sent;
      sender_steady = ($urandom_range(0, 4) == 0);
      send_message(len, $urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  // The sender goes idle first so that no further beat is accepted while draining.
  task automatic drain();
    data_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With no start after reset the stream runs on nonce zero; the nonce port is ignored.
    send_beat(8'h00, 1'b0, '1);
    send_beat(8'hff, 1'b0, '0);
    send_beat(8'h5a, 1'b0, 64'h0123_4567_89ab_cdef);
    // Restart inside a block, then twice in a row.
    send_beat(8'h00, 1'b1, '0);
    send_beat(8'hff, 1'b1, '1);
    send_beat(8'h80, 1'b0, '0);
    send_beat(8'h01, 1'b0, '1);
    send_beat(8'hff, 1'b1, 64'h8000_0000_0000_0001);
    send_beat(8'h7f, 1'b0, '0);
    drain();
    // A key change inside a block only shows from the next block on.
    write_key(KEY_WORD_3, 32'hffff_ffff);
    cfg_write_en <= 1'b0;
    send_beat(8'ha5, 1'b0, '0);
    send_beat(8'h3c, 1'b0, '0);
    drain();
    load_keys({cc20_pkg::KEY_RESET});

    run_traffic(280);
    drain();
    load_keys('0);
    run_traffic(290);
    drain();
    load_keys('1);
    run_traffic(290);
    drain();
    load_keys({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    run_traffic(290);
    drain();
    write_key(key_reg_e'($urandom_range(0, cc20_pkg::NUM_KEY_WORDS - 1)), $urandom);
    cfg_write_en <= 1'b0;
    run_traffic(290);
    drain();
    load_keys({cc20_pkg::KEY_RESET});
    run_traffic(290);
    data_valid <= 1'b0;
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cc20_pkg.sv
sv/cc20_front.sv
sv/cc20_fifo.sv
sv/cc20_core.sv
sv/cc20_back.sv
sv/chacha20_stream_xor_top.sv
sv/cc20_checker.sv
tb/sv/chacha20_stream_xor_top_tb.sv
